// ----- rtl/core/btl_pkg.sv -----
// ============================================================================
// btl_pkg: shared types and constants for the bakery ticket lock arbiter
// Status codes, command codes, state encoding and the control structs
// passed between the ticket memory, the scan unit and the top level.
// ============================================================================
`default_nettype none

package btl_pkg;

  // Fixed field widths of the command and result channels
  localparam int unsigned REQ_W     = 4;
  localparam int unsigned OUT_TKT_W = 16;

  // Default configuration
  localparam int unsigned NUM_REQUESTERS_DEF = 16;
  localparam int unsigned TICKET_BITS_DEF    = 16;

  typedef enum logic {
    CMD_ACQUIRE = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BUSY     = 2'd1,
    STAT_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_COMMIT
  } state_e;

  // Write-side control of the ticket memory
  typedef struct packed {
    logic set;    // write a new ticket and mark the entry live
    logic clear;  // mark the entry idle
  } wr_ctl_t;

  // Read response qualifiers from the ticket memory
  typedef struct packed {
    logic vld;    // read data is present this cycle
    logic live;   // entry holds a nonzero ticket
  } rd_rsp_t;

  // Scan unit control
  typedef struct packed {
    logic clear;    // restart the reductions
    logic excl_en;  // leave the requester's own entry out of the holder search
  } scan_ctl_t;

endpackage : btl_pkg

`default_nettype wire

// ----- rtl/core/btl_ticket_mem.sv -----
// ============================================================================
// btl_ticket_mem: ticket table storage
// One synchronous RAM of tickets with a registered read, plus one live flag
// per entry in flops. An entry that is not live reads as zero.
// ============================================================================
`default_nettype none

module btl_ticket_mem #(
  parameter int unsigned NUM_REQUESTERS = btl_pkg::NUM_REQUESTERS_DEF,
  parameter int unsigned TICKET_BITS    = btl_pkg::TICKET_BITS_DEF,
  localparam int unsigned IDX_W         = $clog2(NUM_REQUESTERS)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // read port
  input  wire logic                   rd_en_i,
  input  wire logic [IDX_W-1:0]       rd_addr_i,
  output      btl_pkg::rd_rsp_t       rd_rsp_o,
  output      logic [IDX_W-1:0]       rd_idx_o,
  output      logic [TICKET_BITS-1:0] rd_data_o,
  // write port
  input  wire btl_pkg::wr_ctl_t       wr_ctl_i,
  input  wire logic [IDX_W-1:0]       wr_addr_i,
  input  wire logic [TICKET_BITS-1:0] wr_data_i
);

  import btl_pkg::*;

  logic [TICKET_BITS-1:0]    mem_q [NUM_REQUESTERS];
  logic [NUM_REQUESTERS-1:0] live_q;
  logic [TICKET_BITS-1:0]    rd_raw_q;
  logic                      rd_live_q;
  logic                      rd_vld_q;
  logic [IDX_W-1:0]          rd_idx_q;

  // RAM write
  always_ff @(posedge clk_i) begin
    if (wr_ctl_i.set) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // RAM read, registered
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_raw_q <= mem_q[rd_addr_i];
    end
  end

  // Live flags: cleared by reset, so the table starts all idle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q    <= '0;
      rd_live_q <= 1'b0;
      rd_vld_q  <= 1'b0;
      rd_idx_q  <= '0;
    end else begin
      if (wr_ctl_i.set) begin
        live_q[wr_addr_i] <= 1'b1;
      end else if (wr_ctl_i.clear) begin
        live_q[wr_addr_i] <= 1'b0;
      end
      rd_vld_q <= rd_en_i;
      if (rd_en_i) begin
        rd_live_q <= live_q[rd_addr_i];
        rd_idx_q  <= rd_addr_i;
      end
    end
  end

  assign rd_rsp_o.vld  = rd_vld_q;
  assign rd_rsp_o.live = rd_live_q;
  assign rd_idx_o      = rd_idx_q;
  assign rd_data_o     = rd_live_q ? rd_raw_q : '0;

endmodule : btl_ticket_mem

`default_nettype wire

// ----- rtl/core/btl_scan.sv -----
// ============================================================================
// btl_scan: max and min reductions over the ticket table
// Consumes one read response per cycle and keeps the largest ticket, the
// holder (smallest ticket, lowest index first) and whether the commanding
// requester's own entry is live.
// ============================================================================
`default_nettype none

module btl_scan #(
  parameter int unsigned NUM_REQUESTERS = btl_pkg::NUM_REQUESTERS_DEF,
  parameter int unsigned TICKET_BITS    = btl_pkg::TICKET_BITS_DEF,
  localparam int unsigned IDX_W         = $clog2(NUM_REQUESTERS)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire btl_pkg::scan_ctl_t     ctl_i,
  input  wire logic [IDX_W-1:0]       req_idx_i,
  input  wire btl_pkg::rd_rsp_t       rd_rsp_i,
  input  wire logic [IDX_W-1:0]       rd_idx_i,
  input  wire logic [TICKET_BITS-1:0] rd_data_i,
  output      logic [TICKET_BITS-1:0] max_o,
  output      logic                   min_found_o,
  output      logic [IDX_W-1:0]       min_idx_o,
  output      logic [TICKET_BITS-1:0] min_tkt_o,
  output      logic                   self_busy_o
);

  import btl_pkg::*;

  logic [TICKET_BITS-1:0] max_q, max_d;
  logic                   found_q, found_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [TICKET_BITS-1:0] tkt_q, tkt_d;
  logic                   busy_q, busy_d;
  logic                   is_self;
  logic                   take_min;

  // One compare for max, one for min per entry
  always_comb begin
    is_self  = (rd_idx_i == req_idx_i);
    take_min = rd_rsp_i.vld && rd_rsp_i.live && !(ctl_i.excl_en && is_self) &&
               (!found_q || (rd_data_i < tkt_q));
    max_d    = max_q;
    found_d  = found_q;
    idx_d    = idx_q;
    tkt_d    = tkt_q;
    busy_d   = busy_q;
    if (ctl_i.clear) begin
      max_d   = '0;
      found_d = 1'b0;
      idx_d   = '0;
      tkt_d   = '0;
      busy_d  = 1'b0;
    end else if (rd_rsp_i.vld && rd_rsp_i.live) begin
      if (rd_data_i > max_q) begin
        max_d = rd_data_i;
      end
      if (take_min) begin
        found_d = 1'b1;
        idx_d   = rd_idx_i;
        tkt_d   = rd_data_i;
      end
      if (is_self) begin
        busy_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q   <= '0;
      found_q <= 1'b0;
      idx_q   <= '0;
      tkt_q   <= '0;
      busy_q  <= 1'b0;
    end else begin
      max_q   <= max_d;
      found_q <= found_d;
      idx_q   <= idx_d;
      tkt_q   <= tkt_d;
      busy_q  <= busy_d;
    end
  end

  assign max_o       = max_q;
  assign min_found_o = found_q;
  assign min_idx_o   = idx_q;
  assign min_tkt_o   = tkt_q;
  assign self_busy_o = busy_q;

  // The holder's ticket never exceeds the largest ticket seen
  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> (tkt_q <= max_q))
    else $error("holder ticket above largest ticket");

  // A holder found means a nonzero ticket
  a_min_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> (tkt_q != '0))
    else $error("holder with zero ticket");

endmodule : btl_scan

`default_nettype wire

// ----- rtl/core/bakery_ticket_lock_arbiter_unit.sv -----
// ============================================================================
// bakery_ticket_lock_arbiter_unit: bakery ticket lock arbiter
// Keeps one ticket per requester in a RAM, hands out max+1 on acquire,
// clears on release and reports the holder with the smallest ticket.
// ============================================================================
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in      | input     | in_valid_i / in_ready_o | command_i, requester_i
//  out     | output    | out_valid_o/out_ready_i | status_o, ticket_given_o,
//          |           |                        | grant_valid_o, grant_holder_o,
//          |           |                        | grant_ticket_o
//
//  Each command makes one RAM read per table entry, then drains the last
//  read and then commits; the single RAM read port sets the length of the
//  scan.
//  Reset clears the per-entry live flags at once; no clearing pass is needed.
//  A new command is taken while the previous result waits on the output; a
//  stalled output holds the commit step and the table write until it drains.
//
`default_nettype none

module bakery_ticket_lock_arbiter_unit #(
  parameter int unsigned NUM_REQUESTERS = btl_pkg::NUM_REQUESTERS_DEF,
  parameter int unsigned TICKET_BITS    = btl_pkg::TICKET_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // command channel
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic                          command_i,
  input  wire logic [btl_pkg::REQ_W-1:0]     requester_i,
  // result channel
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic [1:0]                    status_o,
  output      logic [btl_pkg::OUT_TKT_W-1:0] ticket_given_o,
  output      logic                          grant_valid_o,
  output      logic [btl_pkg::REQ_W-1:0]     grant_holder_o,
  output      logic [btl_pkg::OUT_TKT_W-1:0] grant_ticket_o
);

  import btl_pkg::*;

  localparam int unsigned IDX_W = $clog2(NUM_REQUESTERS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_REQUESTERS - 1);

  state_e                 state_q, state_d;
  cmd_e                   cmd_q;
  logic [REQ_W-1:0]       req_q;
  logic [IDX_W-1:0]       addr_q, addr_d;
  logic [31:0]            req_ext;
  logic [IDX_W-1:0]       req_idx;
  logic                   in_range;
  logic                   in_xfer;
  logic                   load;

  // memory and scan interconnect
  logic                   rd_en;
  rd_rsp_t                rd_rsp;
  logic [IDX_W-1:0]       rd_idx;
  logic [TICKET_BITS-1:0] rd_data;
  wr_ctl_t                wr_ctl;
  scan_ctl_t              scan_ctl;
  logic [TICKET_BITS-1:0] max_tkt;
  logic                   min_found;
  logic [IDX_W-1:0]       min_idx;
  logic [TICKET_BITS-1:0] min_tkt;
  logic                   self_busy;

  // commit results
  logic [TICKET_BITS-1:0] next_tkt;
  logic                   overflow;
  logic                   acq_ok;
  status_e                status_d;
  logic [TICKET_BITS-1:0] given_d;
  logic                   gvalid_d;
  logic [IDX_W-1:0]       gholder_d;
  logic [TICKET_BITS-1:0] gticket_d;

  // output register
  logic                   out_valid_q;
  status_e                status_q;
  logic [OUT_TKT_W-1:0]   given_q;
  logic                   gvalid_q;
  logic [REQ_W-1:0]       gholder_q;
  logic [OUT_TKT_W-1:0]   gticket_q;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign req_ext  = 32'(req_q);
  assign req_idx  = req_ext[IDX_W-1:0];
  assign in_range = (req_ext < 32'(NUM_REQUESTERS));

  // Command capture
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q <= cmd_e'(command_i);
      req_q <= requester_i;
    end
  end

  // State and address counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      addr_q  <= '0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
    end
  end

  // Sequencer: scan all entries, drain, commit
  always_comb begin
    state_d    = state_q;
    addr_d     = addr_q;
    in_ready_o = 1'b0;
    rd_en      = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        addr_d     = '0;
        if (in_valid_i) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        rd_en = 1'b1;
        if (addr_q == LAST_IDX) begin
          state_d = S_LAST;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end
      S_LAST: begin
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        if (load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign scan_ctl.clear   = in_xfer;
  assign scan_ctl.excl_en = in_range && (cmd_q == CMD_RELEASE);

  btl_ticket_mem #(
    .NUM_REQUESTERS(NUM_REQUESTERS),
    .TICKET_BITS   (TICKET_BITS)
  ) u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (rd_en),
    .rd_addr_i(addr_q),
    .rd_rsp_o (rd_rsp),
    .rd_idx_o (rd_idx),
    .rd_data_o(rd_data),
    .wr_ctl_i (wr_ctl),
    .wr_addr_i(req_idx),
    .wr_data_i(next_tkt)
  );

  btl_scan #(
    .NUM_REQUESTERS(NUM_REQUESTERS),
    .TICKET_BITS   (TICKET_BITS)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (scan_ctl),
    .req_idx_i  (req_idx),
    .rd_rsp_i   (rd_rsp),
    .rd_idx_i   (rd_idx),
    .rd_data_i  (rd_data),
    .max_o      (max_tkt),
    .min_found_o(min_found),
    .min_idx_o  (min_idx),
    .min_tkt_o  (min_tkt),
    .self_busy_o(self_busy)
  );

  // Commit decision: status, new ticket and holder after the command
  always_comb begin
    next_tkt  = max_tkt + 1'b1;
    overflow  = &max_tkt;
    acq_ok    = 1'b0;
    status_d  = STAT_OK;
    given_d   = '0;
    gvalid_d  = min_found;
    gholder_d = min_idx;
    gticket_d = min_tkt;
    if (in_range && (cmd_q == CMD_ACQUIRE)) begin
      if (self_busy) begin
        status_d = STAT_BUSY;
      end else if (overflow) begin
        status_d = STAT_OVERFLOW;
      end else begin
        acq_ok  = 1'b1;
        given_d = next_tkt;
        // new ticket is the largest; it holds only if nobody else does
        if (!min_found) begin
          gvalid_d  = 1'b1;
          gholder_d = req_idx;
          gticket_d = next_tkt;
        end
      end
    end
  end

  assign load         = (state_q == S_COMMIT) && (!out_valid_q || out_ready_i);
  assign wr_ctl.set   = load && acq_ok;
  assign wr_ctl.clear = load && in_range && (cmd_q == CMD_RELEASE);

  // Output register: valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register: payload, narrowed to port widths
  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q  <= status_d;
      given_q   <= OUT_TKT_W'(32'(given_d));
      gvalid_q  <= gvalid_d;
      gholder_q <= REQ_W'(32'(gholder_d));
      gticket_q <= OUT_TKT_W'(32'(gticket_d));
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign ticket_given_o = given_q;
  assign grant_valid_o  = gvalid_q;
  assign grant_holder_o = gholder_q;
  assign grant_ticket_o = gticket_q;

  // No grant means holder and ticket read zero
  a_idle_grant_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !grant_valid_o) |-> (grant_holder_o == '0 && grant_ticket_o == '0))
    else $error("grant fields nonzero without a holder");

  // A rejected command never hands out a ticket
  a_reject_no_ticket: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != STAT_OK) |-> (ticket_given_o == '0))
    else $error("ticket given on rejected acquire");

  // A ticket just issued implies someone holds the lock
  a_issue_grants: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ticket_given_o != '0) |-> grant_valid_o)
    else $error("ticket issued but no holder reported");

  // The table is written only at commit, never while a scan runs
  a_write_at_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ctl.set || wr_ctl.clear) |=> (state_q == S_IDLE))
    else $error("table write outside commit");

endmodule : bakery_ticket_lock_arbiter_unit

`default_nettype wire
